>>> rtl/mlbt_pkg.sv
// Shared constants, types and codes of the learning bridge address table.
package mlbt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int MAX_PORTS     = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int MAC_W         = 48;
    localparam int PORT_W        = 4;
    localparam int TIME_W        = 32;
    localparam int PORT_CMP_W    = 9;
    localparam logic [TIME_W-1:0] AGE_RESET = 32'd10000;

    localparam logic MODE_FRAME = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic dst_hit;
        logic src_known;
        logic expired;
    } t_unit_res;

endpackage

>>> rtl/mlbt_ram.sv
// Generic single write port, single read port RAM with registered read data.
module mlbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/mlbt_entry_unit.sv
// Shared compare unit that checks one table entry against the current word.
module mlbt_entry_unit (
    input  mlbt_pkg::t_entry                 i_entry,
    input  logic                             i_entry_valid,
    input  logic [mlbt_pkg::MAC_W-1:0]       i_dst_mac,
    input  logic [mlbt_pkg::MAC_W-1:0]       i_src_mac,
    input  logic [mlbt_pkg::PORT_W-1:0]      i_in_port,
    input  logic [mlbt_pkg::TIME_W-1:0]      i_time,
    input  logic [mlbt_pkg::TIME_W-1:0]      i_age_limit,
    output mlbt_pkg::t_unit_res              o_res
);
    import mlbt_pkg::*;

    logic [TIME_W-1:0] age;

    always_comb begin
        age             = i_time - i_entry.stamp;
        o_res.dst_hit   = i_entry_valid && (i_entry.mac == i_dst_mac);
        o_res.src_known = i_entry_valid && (i_entry.mac == i_src_mac)
                          && (i_entry.port == i_in_port);
        o_res.expired   = i_entry_valid && (age > i_age_limit);
    end

endmodule

>>> rtl/mac_learning_bridge_table.sv
// Top level of the learning bridge address table with aging.
//
// Each accepted word walks the whole table through one RAM read port, one entry per
// cycle: a frame word then passes through S_FIN and S_DONE until its result is loaded,
// and a tick word returns to idle after the walk and gives no result.
// A frame whose result finds the previous one still waiting for the receiver stays in
// its last state until that result is taken. A frame looks up its destination and
// searches for its source in the same walk, then learns the source into the lowest
// free entry. Entry valid bits are flip-flops cleared at reset, so the table is usable
// right after reset. The age limit register accepts writes in every cycle and must be
// written only while the block is idle.
module mac_learning_bridge_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_mode,
    input  logic [mlbt_pkg::PORT_W-1:0]      i_in_port,
    input  logic [mlbt_pkg::MAC_W-1:0]       i_dst_mac,
    input  logic [mlbt_pkg::MAC_W-1:0]       i_src_mac,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [mlbt_pkg::PORT_W-1:0]      o_forward_port,
    output logic                             o_flood,
    output logic                             o_learned,
    output logic                             o_table_full,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mlbt_pkg::TIME_W-1:0]      i_cfg_data
);
    import mlbt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN, S_DONE} t_state;

    t_state              r_state;
    logic [TIME_W-1:0]   r_age_limit;
    logic [TIME_W-1:0]   r_time;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic                r_mode;
    logic [PORT_W-1:0]   r_in_port;
    logic [MAC_W-1:0]    r_dst_mac;
    logic [MAC_W-1:0]    r_src_mac;
    logic                r_port_ok;
    logic [CNT_W-1:0]    r_rd_cnt;
    logic                r_ev_vld;
    logic [IDX_W-1:0]    r_ev_idx;
    logic                r_hit;
    logic [PORT_W-1:0]   r_best;
    logic                r_known;
    logic                r_have_free;
    logic [IDX_W-1:0]    r_free_slot;
    logic                r_res_learned;
    logic                r_res_full;
    logic                r_out_valid;
    logic [PORT_W-1:0]   r_out_port;
    logic                r_out_flood;
    logic                r_out_learned;
    logic                r_out_full;

    logic [IDX_W-1:0]    n_rd_addr;
    logic                ram_we;
    t_entry              ram_wdata;
    t_entry              ram_rdata;
    t_unit_res           unit_res;
    logic                in_acc;
    logic                do_learn;
    logic                out_load;

    assign in_acc   = i_in_valid && o_in_ready;
    assign do_learn = r_port_ok && !r_known && r_have_free;
    assign n_rd_addr = r_rd_cnt[IDX_W-1:0];
    assign ram_we   = (r_state == S_FIN) && (r_mode == MODE_FRAME) && do_learn;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        ram_wdata.mac   = r_src_mac;
        ram_wdata.port  = r_in_port;
        ram_wdata.stamp = r_time;
    end

    mlbt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_slot),
        .i_wdata (ram_wdata),
        .i_raddr (n_rd_addr),
        .o_rdata (ram_rdata)
    );

    mlbt_entry_unit u_unit (
        .i_entry       (ram_rdata),
        .i_entry_valid (r_valid[r_ev_idx]),
        .i_dst_mac     (r_dst_mac),
        .i_src_mac     (r_src_mac),
        .i_in_port     (r_in_port),
        .i_time        (r_time),
        .i_age_limit   (r_age_limit),
        .o_res         (unit_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_age_limit <= AGE_RESET;
            r_time      <= '0;
            r_valid     <= '0;
            r_rd_cnt    <= '0;
            r_ev_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_age_limit <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_mode      <= i_mode;
                        r_in_port   <= i_in_port;
                        r_dst_mac   <= i_dst_mac;
                        r_src_mac   <= i_src_mac;
                        r_port_ok   <= PORT_CMP_W'(i_in_port) < PORT_CMP_W'(MAX_PORTS);
                        r_hit       <= 1'b0;
                        r_best      <= '0;
                        r_known     <= 1'b0;
                        r_have_free <= 1'b0;
                        r_free_slot <= '0;
                        r_rd_cnt    <= '0;
                        r_ev_vld    <= 1'b0;
                        if (i_mode == MODE_TICK) begin
                            r_time <= r_time + 1'b1;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rd_cnt < CNT_W'(TABLE_ENTRIES)) begin
                        r_ev_vld <= 1'b1;
                        r_ev_idx <= n_rd_addr;
                        r_rd_cnt <= r_rd_cnt + 1'b1;
                    end else begin
                        r_ev_vld <= 1'b0;
                    end
                    if (r_ev_vld) begin
                        if (r_mode == MODE_TICK) begin
                            if (unit_res.expired) begin
                                r_valid[r_ev_idx] <= 1'b0;
                            end
                        end else begin
                            if (unit_res.dst_hit) begin
                                if (!r_hit || ram_rdata.port < r_best) begin
                                    r_best <= ram_rdata.port;
                                end
                                r_hit <= 1'b1;
                            end
                            if (unit_res.src_known) begin
                                r_known <= 1'b1;
                            end
                            if (!r_valid[r_ev_idx] && !r_have_free) begin
                                r_have_free <= 1'b1;
                                r_free_slot <= r_ev_idx;
                            end
                        end
                        if (r_ev_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                            r_state <= (r_mode == MODE_TICK) ? S_IDLE : S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (do_learn) begin
                        r_valid[r_free_slot] <= 1'b1;
                    end
                    r_res_learned <= do_learn;
                    r_res_full    <= r_port_ok && !r_known && !r_have_free;
                    r_state       <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_port    <= r_hit ? r_best : '0;
                        r_out_flood   <= !r_hit;
                        r_out_learned <= r_res_learned;
                        r_out_full    <= r_res_full;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_forward_port = r_out_port;
    assign o_flood        = r_out_flood;
    assign o_learned      = r_out_learned;
    assign o_table_full   = r_out_full;

endmodule

>>> rtl/mlbt_checker.sv
// Port level checker of the learning bridge address table and its bind.
module mlbt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [mlbt_pkg::PORT_W-1:0] o_forward_port,
    input logic                        o_flood,
    input logic                        o_learned,
    input logic                        o_table_full
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_forward_port)
        && $stable(o_flood) && $stable(o_learned) && $stable(o_table_full))
        else $error("Result word changed while stalled.");

    a_flood_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_flood |-> o_forward_port == '0)
        else $error("Flooded word carries a forwarding port.");

    a_learn_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_learned && o_table_full))
        else $error("Word is both learned and dropped for a full table.");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Input accepted while the table walk is running.");

endmodule

bind mac_learning_bridge_table mlbt_checker u_mlbt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_forward_port (o_forward_port),
    .o_flood        (o_flood),
    .o_learned      (o_learned),
    .o_table_full   (o_table_full)
);
